>>> design/sbds_pkg.sv
package sbds_pkg;

    // Transform size and the per-bin store it implies.
    localparam int TRANSFORM_LENGTH = 1024;
    localparam int BIN_COUNT        = TRANSFORM_LENGTH / 2 + 1;
    localparam int BIN_W            = 10;
    localparam int MEM_DEPTH        = (BIN_COUNT < (2 ** BIN_W)) ? BIN_COUNT : (2 ** BIN_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_SCALE = 2'd0,
        CFG_MIN_DB       = 2'd1,
        CFG_MAX_DB       = 2'd2,
        CFG_SMOOTHING    = 2'd3
    } sbds_cfg_index_t;

    localparam int RESET_OUTPUT_SCALE = 6850000;
    localparam int RESET_MIN_DB       = -25600;
    localparam int RESET_MAX_DB       = 0;
    localparam int RESET_SMOOTHING    = 45875;

    // Datapath widths.
    localparam int MANT_W      = 32;
    localparam int SUM_W       = 64;
    localparam int GRP_W       = 8;
    localparam int GRP_CNT     = SUM_W / GRP_W;
    localparam int FRAC_W      = 16;
    localparam int SQ_STEPS    = FRAC_W;
    localparam int LOG_N_W     = 6;
    localparam int LOG_W       = LOG_N_W + FRAC_W;
    localparam int SCALE_N_W   = 5;
    localparam int SCALE_LOG_W = SCALE_N_W + FRAC_W;
    localparam int T_W         = 25;
    localparam int PROD_W      = 44;
    localparam int DB_SHIFT    = 24;
    localparam int DB_W        = PROD_W - DB_SHIFT;
    localparam int DIV_W       = 17;
    localparam int LEVEL_W     = 16;
    localparam int WEIGHT_W    = 16;

    // Arithmetic constants.
    localparam int LOG_OFFSET  = 64 * 65536;
    localparam int DB_FLOOR    = -30720;
    localparam int TEN_LOG10_2 = 197283;
    localparam int FULL_LEVEL  = 32768;
    localparam int FULL_WEIGHT = 65536;
    localparam int ROUND_HALF  = 32768;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_index;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
    } sbds_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_number;
        logic [LEVEL_W-1:0] smoothed_level;
    } sbds_out_t;

    // Side information that travels with an item through the sub-pipelines.
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             in_range;
        logic             empty;
    } sbds_tag_t;

    // One squaring step of the log2 fraction: square the Q1.31 mantissa,
    // renormalize, and report the fraction bit in the top position.
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        logic [MANT_W:0]     q;
        p = m * m;
        q = p[2*MANT_W-1:MANT_W-1];
        if (q[MANT_W]) begin
            return {1'b1, q[MANT_W:1]};
        end else begin
            return {1'b0, q[MANT_W-1:0]};
        end
    endfunction

endpackage

>>> design/sbds_log2_pipe.sv
module sbds_log2_pipe
    import sbds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SUM_W-1:0] in_x,
    input  sbds_tag_t        in_tag,
    output logic             out_valid,
    output logic [LOG_W-1:0] out_log,
    output logic             out_zero,
    output sbds_tag_t        out_tag
);

    // Coarse normalization: find the highest nonzero byte.
    logic [2:0]       grp_next;
    logic [2:0]       lzc_next;
    logic [SUM_W-1:0] xs_next;

    always_comb begin
        grp_next = '0;
        for (int g = 0; g < GRP_CNT; g++) begin
            if (in_x[g*GRP_W +: GRP_W] != '0) begin
                grp_next = 3'(g);
            end
        end
        lzc_next = 3'(GRP_CNT - 1) - grp_next;
        xs_next  = in_x << {lzc_next, 3'b000};
    end

    logic             n1_valid_reg;
    logic [SUM_W-1:0] n1_xs_reg;
    logic [2:0]       n1_lzc_reg;
    logic             n1_zero_reg;
    sbds_tag_t        n1_tag_reg;

    // Fine normalization inside the top byte.
    logic [2:0]         pos_next;
    logic [2:0]         lzf_next;
    logic [SUM_W-1:0]   xn_next;
    logic [LOG_N_W-1:0] n_next;

    always_comb begin
        pos_next = '0;
        for (int b = 0; b < GRP_W; b++) begin
            if (n1_xs_reg[SUM_W-GRP_W+b]) begin
                pos_next = 3'(b);
            end
        end
        lzf_next = 3'(GRP_W - 1) - pos_next;
        xn_next  = n1_xs_reg << lzf_next;
        n_next   = LOG_N_W'(SUM_W - 1) - {n1_lzc_reg, lzf_next};
    end

    // Squaring stages, one fraction bit per stage.
    logic                 v_reg    [0:SQ_STEPS];
    logic [MANT_W-1:0]    m_reg    [0:SQ_STEPS];
    logic [FRAC_W-1:0]    frac_reg [0:SQ_STEPS];
    logic [LOG_N_W-1:0]   n_reg    [0:SQ_STEPS];
    logic                 zero_reg [0:SQ_STEPS];
    sbds_tag_t            tag_reg  [0:SQ_STEPS];
    logic [MANT_W:0]      step_next [0:SQ_STEPS-1];
    logic [FRAC_W-1:0]    frac_next [0:SQ_STEPS-1];

    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            step_next[k] = sq_step(m_reg[k]);
            frac_next[k] = frac_reg[k] | (FRAC_W'(step_next[k][MANT_W]) << (FRAC_W - 1 - k));
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_valid_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            n1_valid_reg <= in_valid;
            v_reg[0]     <= n1_valid_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            n1_xs_reg   <= xs_next;
            n1_lzc_reg  <= lzc_next;
            n1_zero_reg <= (in_x == '0);
            n1_tag_reg  <= in_tag;
            m_reg[0]    <= xn_next[SUM_W-1:SUM_W-MANT_W];
            frac_reg[0] <= '0;
            n_reg[0]    <= n_next;
            zero_reg[0] <= n1_zero_reg;
            tag_reg[0]  <= n1_tag_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                m_reg[k+1]    <= step_next[k][MANT_W-1:0];
                frac_reg[k+1] <= frac_next[k];
                n_reg[k+1]    <= n_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS];
    assign out_log   = {n_reg[SQ_STEPS], frac_reg[SQ_STEPS]};
    assign out_zero  = zero_reg[SQ_STEPS];
    assign out_tag   = tag_reg[SQ_STEPS];

endmodule

>>> design/sbds_div_pipe.sv
module sbds_div_pipe
    import sbds_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DIV_W-1:0]   in_num,
    input  logic [DIV_W-1:0]   in_den,
    input  sbds_tag_t          in_tag,
    output logic               out_valid,
    output logic [LEVEL_W-1:0] out_quot,
    output sbds_tag_t          out_tag
);

    // Restoring division of num * 2^15 by den, one quotient bit per stage.
    // The numerator never exceeds the divisor, so the remainder stays below den.
    logic               v_reg   [0:LEVEL_W-1];
    logic [DIV_W-1:0]   r_reg   [0:LEVEL_W-1];
    logic [LEVEL_W-1:0] q_reg   [0:LEVEL_W-1];
    sbds_tag_t          tag_reg [0:LEVEL_W-1];

    logic [DIV_W:0]     rin_next [0:LEVEL_W-1];
    logic               ge_next  [0:LEVEL_W-1];
    logic [DIV_W-1:0]   r_next   [0:LEVEL_W-1];
    logic [LEVEL_W-1:0] q_next   [0:LEVEL_W-1];

    always_comb begin
        rin_next[0] = {1'b0, in_num};
        for (int s = 1; s < LEVEL_W; s++) begin
            rin_next[s] = {r_reg[s-1], 1'b0};
        end
        for (int s = 0; s < LEVEL_W; s++) begin
            ge_next[s] = (rin_next[s] >= {1'b0, in_den});
            r_next[s]  = ge_next[s] ? DIV_W'(rin_next[s] - {1'b0, in_den})
                                    : rin_next[s][DIV_W-1:0];
        end
        q_next[0] = LEVEL_W'(ge_next[0]) << (LEVEL_W - 1);
        for (int s = 1; s < LEVEL_W; s++) begin
            q_next[s] = q_reg[s-1] | (LEVEL_W'(ge_next[s]) << (LEVEL_W - 1 - s));
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LEVEL_W; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < LEVEL_W; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < LEVEL_W; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int s = 0; s < LEVEL_W; s++) begin
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
            end
        end
    end

    assign out_valid = v_reg[LEVEL_W-1];
    assign out_quot  = q_reg[LEVEL_W-1];
    assign out_tag   = tag_reg[LEVEL_W-1];

endmodule

>>> design/spectrum_bin_db_smoother.sv
// Spectrum bin post-processor: magnitude, dB conversion, normalization and
// per-bin exponential smoothing of FFT outputs.
// Input channel s_*: one item per bin (bin index, raw real and imaginary parts).
// Result channel m_*: one item per input item (bin number, smoothed Q1.15 level),
// in input order.
// Configuration: cfg_wr_en/cfg_index/cfg_data write output_scale, min_db,
// max_db and smoothing; write only while no item is in flight.
// Throughput: one item per cycle while s_ready is high. The result is registered
// on m_* after the input, log2, dB, divider and blend stages; the depth is set by the
// 16 squaring stages of the log2 unit and the 16 stages of the level divider.
// A write of output_scale recomputes its log2 in a serial sequencer; while it
// runs, s_ready is low.
// Reset: the smoothing store is cleared one entry per cycle (513 entries) and
// the log2 of the reset scale is computed; s_ready stays low until both finish.
// Stall: when m_ready is low the result holds on m_*; the pipeline keeps taking
// items until its last stage is full, then s_ready drops.
module spectrum_bin_db_smoother
    import sbds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sbds_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sbds_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [18:0]    TEN_LOG10_2_S = 19'(TEN_LOG10_2);
    localparam logic signed [DB_W-1:0] DB_FLOOR_V   = DB_W'(DB_FLOOR);

    typedef enum logic [1:0] {
        SL_IDLE,
        SL_NORM,
        SL_SQUARE
    } sl_state_t;

    // Configuration registers.
    logic [31:0]         output_scale_reg;
    logic signed [15:0]  min_db_reg;
    logic signed [15:0]  max_db_reg;
    logic [WEIGHT_W-1:0] smoothing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_scale_reg <= 32'(RESET_OUTPUT_SCALE);
            min_db_reg       <= 16'(RESET_MIN_DB);
            max_db_reg       <= 16'(RESET_MAX_DB);
            smoothing_reg    <= WEIGHT_W'(RESET_SMOOTHING);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OUTPUT_SCALE: output_scale_reg <= cfg_data;
                CFG_MIN_DB:       min_db_reg       <= cfg_data[15:0];
                CFG_MAX_DB:       max_db_reg       <= cfg_data[15:0];
                CFG_SMOOTHING:    smoothing_reg    <= cfg_data[WEIGHT_W-1:0];
            endcase
        end
    end

    // Sequencer that computes log2 of the scale factor after reset or a write.
    sl_state_t                 sl_state_reg;
    logic [MANT_W-1:0]         sl_m_reg;
    logic [SCALE_N_W-1:0]      sl_n_reg;
    logic [FRAC_W-1:0]         sl_frac_reg;
    logic [$clog2(FRAC_W)-1:0] sl_idx_reg;
    logic [SCALE_LOG_W-1:0]    scale_log_reg;
    logic [MANT_W:0]           sl_step_next;
    logic [FRAC_W-1:0]         sl_frac_next;

    assign sl_step_next = sq_step(sl_m_reg);
    assign sl_frac_next = sl_frac_reg | (FRAC_W'(sl_step_next[MANT_W]) << sl_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sl_state_reg  <= SL_NORM;
            sl_m_reg      <= MANT_W'(RESET_OUTPUT_SCALE);
            sl_n_reg      <= SCALE_N_W'(MANT_W - 1);
            sl_frac_reg   <= '0;
            sl_idx_reg    <= '0;
            scale_log_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == CFG_OUTPUT_SCALE)) begin
            sl_state_reg <= SL_NORM;
            sl_m_reg     <= cfg_data;
            sl_n_reg     <= SCALE_N_W'(MANT_W - 1);
            sl_frac_reg  <= '0;
        end else begin
            unique case (sl_state_reg)
                SL_IDLE: begin
                    sl_state_reg <= SL_IDLE;
                end
                SL_NORM: begin
                    if (sl_m_reg == '0) begin
                        sl_state_reg <= SL_IDLE;
                    end else if (sl_m_reg[MANT_W-1]) begin
                        sl_state_reg <= SL_SQUARE;
                        sl_idx_reg   <= $clog2(FRAC_W)'(FRAC_W - 1);
                    end else begin
                        sl_m_reg <= sl_m_reg << 1;
                        sl_n_reg <= sl_n_reg - 1'b1;
                    end
                end
                SL_SQUARE: begin
                    sl_m_reg    <= sl_step_next[MANT_W-1:0];
                    sl_frac_reg <= sl_frac_next;
                    sl_idx_reg  <= sl_idx_reg - 1'b1;
                    if (sl_idx_reg == '0) begin
                        sl_state_reg  <= SL_IDLE;
                        scale_log_reg <= {sl_n_reg, sl_frac_next};
                    end
                end
                default: begin
                    sl_state_reg <= SL_IDLE;
                end
            endcase
        end
    end

    // Clearing pass over the smoothing store after reset.
    logic             clr_active_reg;
    logic [BIN_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_cnt_reg == BIN_W'(MEM_DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Pipeline advance: everything moves unless the final stage is full and
    // the output register cannot drain.
    logic a_valid_reg;
    logic m_valid_reg;
    logic en;
    logic o_load;

    assign o_load  = !m_valid_reg || m_ready;
    assign en      = !a_valid_reg || o_load;
    assign s_ready = en && !clr_active_reg && (sl_state_reg == SL_IDLE);

    // Stage 1: absolute values.
    logic [31:0] re_abs_next;
    logic [31:0] im_abs_next;
    sbds_tag_t   tag1_next;

    assign re_abs_next = s_data.real_part[31] ? (~s_data.real_part + 32'd1) : s_data.real_part;
    assign im_abs_next = s_data.imag_part[31] ? (~s_data.imag_part + 32'd1) : s_data.imag_part;

    always_comb begin
        tag1_next.bin      = s_data.bin_index;
        tag1_next.in_range = (s_data.bin_index < BIN_COUNT);
        tag1_next.empty    = 1'b0;
    end

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [31:0] re_abs_reg, im_abs_reg;
    sbds_tag_t   tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;

    // Stage 2: squares.
    logic [SUM_W-1:0] re_sq_next, im_sq_next;
    logic [SUM_W-1:0] re_sq_reg, im_sq_reg;

    assign re_sq_next = re_abs_reg * re_abs_reg;
    assign im_sq_next = im_abs_reg * im_abs_reg;

    // Stage 3: sum of squares.
    logic [SUM_W-1:0] sum_reg;

    // Log2 of the power.
    logic             lg_valid;
    logic [LOG_W-1:0] lg_log;
    logic             lg_zero;
    sbds_tag_t        lg_tag;

    sbds_log2_pipe u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_x      (sum_reg),
        .in_tag    (tag3_reg),
        .out_valid (lg_valid),
        .out_log   (lg_log),
        .out_zero  (lg_zero),
        .out_tag   (lg_tag)
    );

    // Stage 4: log2 of the scaled power, Q.16.
    logic signed [T_W-1:0] t_next;
    logic signed [T_W-1:0] t_reg;
    logic                  zero4_reg;

    assign t_next = $signed({3'b000, lg_log}) + $signed({3'b000, scale_log_reg, 1'b0})
                  - T_W'(LOG_OFFSET);

    // Stage 5: conversion to dB.
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     zero5_reg;

    assign prod_next = t_reg * TEN_LOG10_2_S;

    // Stage 6: floor, clamps and offset from the lower bound.
    logic signed [DB_W-1:0] db_raw, db_a, db_b, db_c, db_d;
    logic signed [DB_W-1:0] min_ext, max_ext, diff_next;
    logic [DIV_W-1:0]       d_next;
    logic [DIV_W-1:0]       d_reg;
    logic [DIV_W-1:0]       den_value;
    logic                   empty_range;

    assign min_ext     = DB_W'(min_db_reg);
    assign max_ext     = DB_W'(max_db_reg);
    assign empty_range = (max_db_reg <= min_db_reg);
    assign den_value   = {max_db_reg[15], max_db_reg} - {min_db_reg[15], min_db_reg};

    always_comb begin
        db_raw    = prod_reg[PROD_W-1:DB_SHIFT];
        db_a      = zero5_reg ? DB_FLOOR_V : db_raw;
        db_b      = (db_a < DB_FLOOR_V) ? DB_FLOOR_V : db_a;
        db_c      = (db_b < min_ext) ? min_ext : db_b;
        db_d      = (db_c > max_ext) ? max_ext : db_c;
        diff_next = db_d - min_ext;
        d_next    = diff_next[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= lg_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_abs_reg <= re_abs_next;
            im_abs_reg <= im_abs_next;
            tag1_reg   <= tag1_next;
            re_sq_reg  <= re_sq_next;
            im_sq_reg  <= im_sq_next;
            tag2_reg   <= tag1_reg;
            sum_reg    <= re_sq_reg + im_sq_reg;
            tag3_reg   <= tag2_reg;
            t_reg      <= t_next;
            zero4_reg  <= lg_zero || (output_scale_reg == '0);
            tag4_reg   <= lg_tag;
            prod_reg   <= prod_next;
            zero5_reg  <= zero4_reg;
            tag5_reg   <= tag4_reg;
            d_reg      <= d_next;
            tag6_reg.bin      <= tag5_reg.bin;
            tag6_reg.in_range <= tag5_reg.in_range;
            tag6_reg.empty    <= empty_range;
        end
    end

    // Normalization to the Q1.15 level.
    logic               q_valid;
    logic [LEVEL_W-1:0] q_quot;
    sbds_tag_t          q_tag;

    sbds_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    (d_reg),
        .in_den    (den_value),
        .in_tag    (tag6_reg),
        .out_valid (q_valid),
        .out_quot  (q_quot),
        .out_tag   (q_tag)
    );

    // Blend stage: store read data arrives with the item; a write of the same
    // bin by the item just ahead is forwarded instead.
    logic [BIN_W-1:0]   a_bin_reg;
    logic               a_in_range_reg;
    logic [LEVEL_W-1:0] a_level_reg;
    logic [LEVEL_W-1:0] rd_reg;
    logic               fwd_reg;
    logic [LEVEL_W-1:0] fwd_val_reg;

    logic [LEVEL_W-1:0]    old_next;
    logic [WEIGHT_W:0]     inv_weight;
    logic [31:0]           keep_next;
    logic [32:0]           add_next;
    logic [33:0]           blend_sum;
    logic [LEVEL_W-1:0]    blend_next;
    logic                  store_wr;

    assign old_next   = fwd_reg ? fwd_val_reg : rd_reg;
    assign inv_weight = (WEIGHT_W + 1)'(FULL_WEIGHT) - {1'b0, smoothing_reg};
    assign keep_next  = old_next * smoothing_reg;
    assign add_next   = a_level_reg * inv_weight;
    assign blend_sum  = 34'(keep_next) + 34'(add_next) + 34'(ROUND_HALF);
    assign blend_next = blend_sum[WEIGHT_W +: LEVEL_W];
    assign store_wr   = en && a_valid_reg && a_in_range_reg;

    logic [LEVEL_W-1:0] store_mem [0:MEM_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            store_mem[clr_cnt_reg] <= '0;
        end else if (store_wr) begin
            store_mem[a_bin_reg] <= blend_next;
        end
        if (en) begin
            rd_reg <= store_mem[q_tag.bin];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_bin_reg      <= q_tag.bin;
            a_in_range_reg <= q_tag.in_range;
            a_level_reg    <= q_tag.empty ? '0 : q_quot;
            fwd_reg        <= a_valid_reg && a_in_range_reg && (a_bin_reg == q_tag.bin);
            fwd_val_reg    <= blend_next;
        end
    end

    // Output register.
    sbds_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_load) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            m_data_reg.bin_number     <= a_bin_reg;
            m_data_reg.smoothed_level <= a_in_range_reg ? blend_next : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("item accepted during store clearing");

    a_no_accept_while_scale_log: assert property (@(posedge aclk) disable iff (!aresetn)
        (sl_state_reg != SL_IDLE) |-> !s_ready)
        else $error("item accepted while scale log is computed");

    a_no_store_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !store_wr)
        else $error("store written by an item during clearing");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.smoothed_level <= FULL_LEVEL))
        else $error("smoothed level above full scale");

    a_out_of_range_bin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.bin_number >= BIN_COUNT))
            |-> (m_data_reg.smoothed_level == '0))
        else $error("out-of-range bin produced a nonzero level");

    a_blend_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && m_valid_reg && !m_ready) |=> (a_valid_reg && $stable(a_bin_reg)))
        else $error("blend stage lost its item during a stall");
`endif

endmodule
